// ===== rtl/tpat_pkg.sv =====
`default_nettype none

package tpat_pkg;

    localparam logic [7:0] PRESCALE_LIMIT_RESET    = 8'd6;
    localparam logic [7:0] TICKS_PER_SECOND_RESET  = 8'd60;
    localparam int unsigned CLOCK_IRQ_BIT          = 6;
    localparam int unsigned SLOT_W                 = 4;
    localparam int unsigned SECONDS_W              = 16;
    localparam int unsigned COUNT_W                = 32;
    localparam int unsigned QUEUE_DEPTH            = 2;

    // register indexes on the configuration port
    localparam logic REG_PRESCALE_LIMIT   = 1'b0;
    localparam logic REG_TICKS_PER_SECOND = 1'b1;

    typedef enum logic [1:0] {
        KIND_DONE     = 2'd0,
        KIND_ALARM    = 2'd1,
        KIND_SPURIOUS = 2'd2,
        KIND_TICK     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NOTICK  = 2'd1,
        OP_SPUR    = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic                  running;
        logic                  in_system;
        logic                  load_en;
        logic [SLOT_W-1:0]     slot;
        logic [SECONDS_W-1:0]  seconds;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/tick_prescaler_alarm_timer_unit.sv =====
`default_nettype none

// Channel   Handshake               Payload
// --------  ----------------------  ----------------------------------------------
// cmd       cmd_valid / cmd_ready   command, irq_status, proc_running, in_system,
//                                   alarm_slot, alarm_seconds
// res       res_valid / res_ready   kind, slot, total_ticks, user_ticks,
//                                   system_ticks, last
// apb       psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// Loads, spurious and non-tick interrupts and ticks off a second boundary are each
// done in ST_IDLE. A tick on a second boundary walks the alarm table (at most 16
// slots) one slot per cycle through a single table port, pausing on output stalls.
// The front classifies and runs the prescaler; a 2-entry queue decouples it from
// the back, so transfers are taken while a result waits on res_ready, until full.
// Reset (rst_n, async) clears all counters, the alarm table and the queue.
module tick_prescaler_alarm_timer_unit
    import tpat_pkg::*;
#(
    parameter int unsigned ALARM_SLOTS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire logic                  command,
    input  wire logic [7:0]            irq_status,
    input  wire logic                  proc_running,
    input  wire logic                  in_system,
    input  wire logic [SLOT_W-1:0]     alarm_slot,
    input  wire logic [SECONDS_W-1:0]  alarm_seconds,
    // result channel
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic [1:0]                 kind,
    output logic [SLOT_W-1:0]          slot,
    output logic [COUNT_W-1:0]         total_ticks,
    output logic [COUNT_W-1:0]         user_ticks,
    output logic [COUNT_W-1:0]         system_ticks,
    output logic                       last,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // the slot field is 4 bits, so no more than 16 slots can be addressed
    localparam int unsigned TableDepth = (ALARM_SLOTS < (1 << SLOT_W)) ?
                                         ALARM_SLOTS : (1 << SLOT_W);

    logic [7:0]  prescale_limit_reg;
    logic [7:0]  tps_reg;
    logic        cfg_write;
    logic        q_full;
    logic        q_valid;
    logic        push;
    logic        pop;
    entry_t      push_entry;
    entry_t      head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prescale_limit_reg <= PRESCALE_LIMIT_RESET;
            tps_reg            <= TICKS_PER_SECOND_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_PRESCALE_LIMIT) begin
                prescale_limit_reg <= pwdata[7:0];
            end else begin
                tps_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PRESCALE_LIMIT:   prdata = {24'd0, prescale_limit_reg};
            REG_TICKS_PER_SECOND: prdata = {24'd0, tps_reg};
            default:              prdata = '0;
        endcase
    end

    // front: accept and classify, prescaler decides tick / no tick
    tpat_front #(
        .TABLE_DEPTH (TableDepth)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .command        (command),
        .irq_status     (irq_status),
        .proc_running   (proc_running),
        .in_system      (in_system),
        .alarm_slot     (alarm_slot),
        .alarm_seconds  (alarm_seconds),
        .prescale_limit (prescale_limit_reg),
        .q_full         (q_full),
        .push           (push),
        .entry          (push_entry)
    );

    tpat_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    // back: counters, seconds divider, alarm walk, result register
    tpat_back #(
        .TABLE_DEPTH (TableDepth)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .head             (head),
        .pop              (pop),
        .ticks_per_second (tps_reg),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .kind             (kind),
        .slot             (slot),
        .total_ticks      (total_ticks),
        .user_ticks       (user_ticks),
        .system_ticks     (system_ticks),
        .last             (last)
    );

endmodule

`default_nettype wire

// ===== rtl/tpat_front.sv =====
`default_nettype none

module tpat_front
    import tpat_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire logic                  command,
    input  wire logic [7:0]            irq_status,
    input  wire logic                  proc_running,
    input  wire logic                  in_system,
    input  wire logic [SLOT_W-1:0]     alarm_slot,
    input  wire logic [SECONDS_W-1:0]  alarm_seconds,
    input  wire logic [7:0]            prescale_limit,
    input  wire logic                  q_full,
    output logic                       push,
    output entry_t                     entry
);

    logic [7:0] prescale_reg;
    logic [7:0] prescale_next;

    assign cmd_ready = !q_full;
    assign push      = cmd_valid && cmd_ready;

    always_comb
    begin
        prescale_next   = prescale_reg;
        entry.running   = proc_running;
        entry.in_system = in_system;
        entry.slot      = alarm_slot;
        entry.seconds   = alarm_seconds;
        entry.load_en   = ({1'b0, alarm_slot} < (SLOT_W + 1)'(TABLE_DEPTH));
        if (command) begin
            entry.op = OP_LOAD;
        end else if (!irq_status[CLOCK_IRQ_BIT]) begin
            entry.op = OP_SPUR;
        end else if (prescale_reg < prescale_limit) begin
            entry.op      = OP_NOTICK;
            prescale_next = prescale_reg + 8'd1;
        end else begin
            entry.op      = OP_TICK;
            prescale_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prescale_reg <= 8'd0;
        end else if (push) begin
            prescale_reg <= prescale_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpat_queue.sv =====
`default_nettype none

module tpat_queue
    import tpat_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire entry_t  push_entry,
    output logic         full,
    input  wire logic    pop,
    output logic         q_valid,
    output entry_t       head
);

    localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg;
    logic [PtrW-1:0]    rd_ptr_reg;
    logic [CntW-1:0]    count_reg;
    logic [PtrW-1:0]    wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_next;
    logic [CntW-1:0]    count_next;

    assign full    = (count_reg == CntW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpat_back.sv =====
`default_nettype none

module tpat_back
    import tpat_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire entry_t              head,
    output logic                     pop,
    input  wire logic [7:0]          ticks_per_second,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output logic [1:0]               kind,
    output logic [SLOT_W-1:0]        slot,
    output logic [COUNT_W-1:0]       total_ticks,
    output logic [COUNT_W-1:0]       user_ticks,
    output logic [COUNT_W-1:0]       system_ticks,
    output logic                     last
);

    localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    back_state_t             state_reg, state_next;
    logic [IdxW-1:0]         idx_reg, idx_next;
    logic [7:0]              divider_reg, divider_next;
    logic [COUNT_W-1:0]      total_reg, total_next;
    logic [COUNT_W-1:0]      user_reg, user_next;
    logic [COUNT_W-1:0]      sys_reg, sys_next;
    logic                    res_valid_reg, res_valid_next;
    kind_t                   kind_reg, kind_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    last_reg, last_next;
    logic [SECONDS_W-1:0]    alarm_reg [TABLE_DEPTH];

    logic                    out_free;
    logic                    tbl_we;
    logic [IdxW-1:0]         tbl_addr;
    logic [SECONDS_W-1:0]    tbl_wdata;
    logic [SECONDS_W-1:0]    cur_alarm;
    logic [7:0]              divider_inc;

    // output register is free once empty or drained this cycle
    assign out_free    = !res_valid_reg || res_ready;
    assign cur_alarm   = alarm_reg[idx_reg];
    assign divider_inc = divider_reg + 8'd1;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        divider_next   = divider_reg;
        total_next     = total_reg;
        user_next      = user_reg;
        sys_next       = sys_reg;
        res_valid_next = res_valid_reg && !res_ready;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        tbl_we         = 1'b0;
        tbl_addr       = idx_reg;
        tbl_wdata      = cur_alarm - 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free) begin
                    pop            = 1'b1;
                    res_valid_next = 1'b1;
                    slot_next      = '0;
                    last_next      = 1'b1;
                    case (head.op)
                        OP_LOAD:
                        begin
                            tbl_we    = head.load_en;
                            tbl_addr  = head.slot[IdxW-1:0];
                            tbl_wdata = head.seconds;
                            kind_next = KIND_DONE;
                        end
                        OP_NOTICK:
                        begin
                            kind_next = KIND_DONE;
                        end
                        OP_SPUR:
                        begin
                            kind_next = KIND_SPURIOUS;
                        end
                        OP_TICK:
                        begin
                            total_next = total_reg + 1'b1;
                            if (head.running) begin
                                if (head.in_system) begin
                                    sys_next = sys_reg + 1'b1;
                                end else begin
                                    user_next = user_reg + 1'b1;
                                end
                            end
                            kind_next = KIND_TICK;
                            if (divider_inc == ticks_per_second) begin
                                // second boundary: walk the alarms, hold the entry
                                divider_next   = 8'd0;
                                idx_next       = '0;
                                state_next     = ST_WALK;
                                pop            = 1'b0;
                                res_valid_next = 1'b0;
                            end else begin
                                divider_next = divider_inc;
                            end
                        end
                        default:
                        begin
                            kind_next = KIND_DONE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (out_free) begin
                    if (cur_alarm != '0) begin
                        tbl_we = 1'b1;
                        if (cur_alarm == SECONDS_W'(1)) begin
                            res_valid_next = 1'b1;
                            kind_next      = KIND_ALARM;
                            slot_next      = SLOT_W'(idx_reg);
                            last_next      = 1'b0;
                        end
                    end
                    if (idx_reg == IdxW'(TABLE_DEPTH - 1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free) begin
                    pop            = 1'b1;
                    res_valid_next = 1'b1;
                    kind_next      = KIND_TICK;
                    slot_next      = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            divider_reg   <= 8'd0;
            total_reg     <= '0;
            user_reg      <= '0;
            sys_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                alarm_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            divider_reg   <= divider_next;
            total_reg     <= total_next;
            user_reg      <= user_next;
            sys_reg       <= sys_next;
            res_valid_reg <= res_valid_next;
            if (tbl_we) begin
                alarm_reg[tbl_addr] <= tbl_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        slot_reg <= slot_next;
        last_reg <= last_next;
    end

    // counters change only while no unread result is held, so they feed the port directly
    assign res_valid    = res_valid_reg;
    assign kind         = kind_reg;
    assign slot         = slot_reg;
    assign last         = last_reg;
    assign total_ticks  = total_reg;
    assign user_ticks   = user_reg;
    assign system_ticks = sys_reg;

endmodule

`default_nettype wire

// ===== tb/tpat_checker.sv =====
module tpat_checker
    import tpat_pkg::*;
#(
    parameter int unsigned ALARM_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  logic                  cmd_ready,
    input  logic                  command,
    input  logic [7:0]            irq_status,
    input  logic                  proc_running,
    input  logic                  in_system,
    input  logic [SLOT_W-1:0]     alarm_slot,
    input  logic [SECONDS_W-1:0]  alarm_seconds,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  logic [1:0]            kind,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [COUNT_W-1:0]    total_ticks,
    input  logic [COUNT_W-1:0]    user_ticks,
    input  logic [COUNT_W-1:0]    system_ticks,
    input  logic                  last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output int                    errors,
    output int                    pending
);

    localparam logic CMD_LOAD = 1'b1;
    localparam int unsigned TABLE_DEPTH = 1 << SLOT_W;
    localparam int unsigned LIVE_SLOTS  =
        (ALARM_SLOTS < TABLE_DEPTH) ? ALARM_SLOTS : TABLE_DEPTH;

    typedef struct {
        kind_t                kind;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   total;
        logic [COUNT_W-1:0]   user_time;
        logic [COUNT_W-1:0]   sys_time;
        logic                 last;
    } timer_result_t;

    logic [7:0]            prescale_limit_q;
    logic [7:0]            ticks_per_second_q;
    logic [7:0]            prescale_cnt;
    logic [7:0]            second_div;
    logic [COUNT_W-1:0]    global_cnt;
    logic [COUNT_W-1:0]    user_cnt;
    logic [COUNT_W-1:0]    system_cnt;
    logic [SECONDS_W-1:0]  alarm_left [TABLE_DEPTH];
    timer_result_t         expected_results [$];

    // snapshot of the counters goes with every result
    task automatic post_result(input kind_t k, input logic [SLOT_W-1:0] s, input logic l);
        timer_result_t r;
        r.kind      = k;
        r.slot      = s;
        r.total     = global_cnt;
        r.user_time = user_cnt;
        r.sys_time  = system_cnt;
        r.last      = l;
        expected_results.push_back(r);
    endtask

    // the prescaler count and the seconds divider are not visible at the ports
    task automatic advance_timer(input logic cmd, input logic [7:0] status,
                                 input logic run, input logic sys,
                                 input logic [SLOT_W-1:0] aslot,
                                 input logic [SECONDS_W-1:0] asec);
        if (cmd == CMD_LOAD) begin
            if (aslot < LIVE_SLOTS)
                alarm_left[aslot] = asec;
            post_result(KIND_DONE, '0, 1'b1);
        end
        else if (!status[CLOCK_IRQ_BIT]) begin
            post_result(KIND_SPURIOUS, '0, 1'b1);
        end
        else if (prescale_cnt < prescale_limit_q) begin
            prescale_cnt = prescale_cnt + 8'd1;
            post_result(KIND_DONE, '0, 1'b1);
        end
        else begin
            prescale_cnt = '0;
            if (run) begin
                if (sys)
                    system_cnt = system_cnt + 1;
                else
                    user_cnt = user_cnt + 1;
            end
            global_cnt = global_cnt + 1;
            second_div = second_div + 8'd1;
            if (second_div == ticks_per_second_q) begin
                second_div = '0;
                for (int i = 0; i < LIVE_SLOTS; i++) begin
                    if (alarm_left[i] != '0) begin
                        alarm_left[i] = alarm_left[i] - 1'b1;
                        if (alarm_left[i] == '0)
                            post_result(KIND_ALARM, SLOT_W'(i), 1'b0);
                    end
                end
            end
            post_result(KIND_TICK, '0, 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        timer_result_t want;
        if (!rst_n) begin
            prescale_limit_q   = PRESCALE_LIMIT_RESET;
            ticks_per_second_q = TICKS_PER_SECOND_RESET;
            prescale_cnt       = '0;
            second_div         = '0;
            global_cnt         = '0;
            user_cnt           = '0;
            system_cnt         = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                alarm_left[i] = '0;
            expected_results.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_PRESCALE_LIMIT)
                    prescale_limit_q = pwdata[7:0];
                else
                    ticks_per_second_q = pwdata[7:0];
            end
            if (cmd_valid && cmd_ready)
                advance_timer(command, irq_status, proc_running, in_system,
                              alarm_slot, alarm_seconds);
            if (res_valid && res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: kind %0d slot %0d", kind, slot);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("kind", COUNT_W'(want.kind), COUNT_W'(kind));
                    check_field("slot", COUNT_W'(want.slot), COUNT_W'(slot));
                    check_field("total_ticks", want.total, total_ticks);
                    check_field("user_ticks", want.user_time, user_ticks);
                    check_field("system_ticks", want.sys_time, system_ticks);
                    check_field("last", COUNT_W'(want.last), COUNT_W'(last));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_tick_prescaler_alarm_timer_unit.sv =====
module tb_tick_prescaler_alarm_timer_unit;
    import tpat_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int unsigned ALARM_SLOTS = 16;
    // receiver hold-off that backs the queue up into the command channel
    localparam int LONG_HOLD = 400;
    // quiet time after the last result: a full alarm walk plus margin
    localparam int END_WAIT = ALARM_SLOTS + 16;
    // generous run limit in cycles
    localparam int RUN_LIMIT = 1_500_000;

    localparam logic CMD_IRQ  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct {
        logic                  cmd;
        logic [7:0]            status;
        logic                  running;
        logic                  sys;
        logic [SLOT_W-1:0]     aslot;
        logic [SECONDS_W-1:0]  asec;
    } timer_cmd_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_ready;
    logic                  command;
    logic [7:0]            irq_status;
    logic                  proc_running;
    logic                  in_system;
    logic [SLOT_W-1:0]     alarm_slot;
    logic [SECONDS_W-1:0]  alarm_seconds;
    logic                  res_valid;
    logic                  res_ready;
    logic [1:0]            kind;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_W-1:0]    total_ticks;
    logic [COUNT_W-1:0]    user_ticks;
    logic [COUNT_W-1:0]    system_ticks;
    logic                  last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int                    fail_count;
    int                    results_due;
    bit                    hold_req;
    bit                    hold_done;

    tick_prescaler_alarm_timer_unit #(.ALARM_SLOTS(ALARM_SLOTS)) dut (.*);

    // scoreboard: snoops the command, result and config transfers
    tpat_checker #(.ALARM_SLOTS(ALARM_SLOTS)) timer_checker (
        .*,
        .errors  (fail_count),
        .pending (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(50, 20);
    endfunction

    function automatic timer_cmd_t irq_item(input logic [7:0] status, input logic run,
                                            input logic sys);
        timer_cmd_t c;
        c.cmd     = CMD_IRQ;
        c.status  = status;
        c.running = run;
        c.sys     = sys;
        c.aslot   = SLOT_W'($urandom);
        c.asec    = SECONDS_W'($urandom);
        return c;
    endfunction

    function automatic timer_cmd_t load_item(input logic [SLOT_W-1:0] s,
                                             input logic [SECONDS_W-1:0] secs);
        timer_cmd_t c;
        c.cmd     = CMD_LOAD;
        c.status  = 8'($urandom);
        c.running = 1'($urandom);
        c.sys     = 1'($urandom);
        c.aslot   = s;
        c.asec    = secs;
        return c;
    endfunction

    // Random item: loads use mostly short alarm times so slots really expire,
    // spurious ones clear the clock bit, the rest are valid clock interrupts.
    function automatic timer_cmd_t random_item(input int load_pct, input int spur_pct);
        int roll;
        int secs_roll;
        logic [SECONDS_W-1:0] secs;
        logic [7:0] status;
        roll = $urandom_range(99);
        status = 8'($urandom);
        if (roll < load_pct) begin
            secs_roll = $urandom_range(99);
            if (secs_roll < 10)
                secs = '0;
            else if (secs_roll < 75)
                secs = SECONDS_W'($urandom_range(4, 1));
            else
                secs = SECONDS_W'($urandom);
            return load_item(SLOT_W'($urandom), secs);
        end
        else if (roll < load_pct + spur_pct) begin
            status[CLOCK_IRQ_BIT] = 1'b0;
            return irq_item(status, 1'($urandom), 1'($urandom));
        end
        else begin
            status[CLOCK_IRQ_BIT] = 1'b1;
            return irq_item(status, 1'($urandom), 1'($urandom));
        end
    endfunction

    // Called at a falling edge, returns at the falling edge after the transfer.
    // valid stays high across back-to-back items.
    task automatic push_cmd(input timer_cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid     <= 1'b1;
        command       <= c.cmd;
        irq_status    <= c.status;
        proc_running  <= c.running;
        in_system     <= c.sys;
        alarm_slot    <= c.aslot;
        alarm_seconds <= c.asec;
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
    endtask

    // drop valid and wait for every expected result to come back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do @(negedge clk); while (results_due != 0);
    endtask

    // writes both registers back to back; only called while the block is idle
    task automatic set_config(input logic [7:0] limit, input logic [7:0] tps);
        for (int r = 0; r < 2; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {(r == 0) ? REG_PRESCALE_LIMIT : REG_TICKS_PER_SECOND, 2'b00};
            pwdata  <= 32'((r == 0) ? limit : tps);
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            @(negedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int load_pct, input int spur_pct);
        for (int n = 0; n < count; n++)
            push_cmd(random_item(load_pct, spur_pct));
    endtask

    // Result side: ready stretches and stall stretches of random length, plus
    // one long hold-off on request so the queue fills and cmd_ready drops.
    initial
    begin
        int  run_left;
        bit  level;
        int  roll;
        res_ready = 1'b0;
        run_left  = 0;
        level     = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                run_left = 0;
            end
            if (run_left == 0) begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    level    = 1'b1;
                    run_left = $urandom_range(40, 1);
                end
                else begin
                    level = 1'b0;
                    if (roll < 85)
                        run_left = $urandom_range(3, 1);
                    else if (roll < 97)
                        run_left = $urandom_range(12, 4);
                    else
                        run_left = $urandom_range(60, 20);
                end
            end
            res_ready <= level;
            run_left--;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        command       = CMD_IRQ;
        irq_status    = '0;
        proc_running  = 1'b0;
        in_system     = 1'b0;
        alarm_slot    = '0;
        alarm_seconds = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset config (PRESCALE_LIMIT_RESET and TICKS_PER_SECOND_RESET).
        // Slot 0 armed; spurious with all-zero and all-but-clock-bit status.
        push_cmd(load_item('0, 16'd1));
        push_cmd(irq_item(8'h00, 1'b1, 1'b1));
        push_cmd(irq_item(8'hBF, 1'b0, 1'b0));
        for (int n = 0; n < 7; n++)
            push_cmd(irq_item((n % 2 == 0) ? 8'h40 : 8'hFF, 1'b1, n[1]));
        wait_drained();

        // every clock irq a tick, 1 tick/s set, but the divider stands at 1: no alarm expires
        set_config(8'd0, 8'd1);
        push_cmd(load_item(4'hF, 16'd1));
        push_cmd(load_item(4'd3, 16'd2));
        push_cmd(load_item(4'd5, 16'hFFFF));
        push_cmd(load_item(4'd5, 16'd0));        // disable again
        push_cmd(irq_item(8'h40, 1'b1, 1'b0));   // tick, divider not at the boundary
        push_cmd(irq_item(8'hC0, 1'b1, 1'b1));   // tick
        push_cmd(irq_item(8'h7F, 1'b0, 1'b0));   // tick
        push_cmd(irq_item(8'h80, 1'b1, 1'b0));
        push_cmd(load_item(4'hF, 16'hFFFF));
        wait_drained();

        // short periods, frequent expiries; long receiver hold-off here
        set_config(8'd1, 8'd2);
        hold_req = 1'b1;
        run_phase(70, 20, 10);
        wait_drained();

        // top divider value, lets the seconds divider climb
        set_config(8'd0, 8'd255);
        run_phase(50, 5, 5);
        wait_drained();

        // divider register zero, starting above it: wraps through 256
        set_config(8'd0, 8'd0);
        run_phase(240, 5, 5);
        wait_drained();

        // top prescale limit, builds up a large prescaler count
        set_config(8'd255, 8'd1);
        run_phase(20, 10, 10);
        wait_drained();

        // limit lowered below the count: next clock irq ticks
        set_config(8'd3, 8'd1);
        run_phase(25, 15, 10);
        wait_drained();

        repeat (END_WAIT) @(negedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
